>>> rtl/rlm_pkg.sv
`timescale 1ns / 1ps
package rlm_pkg;

  localparam int MAX_TXNS  = 16;
  localparam int MAX_NOTES = 16;
  localparam int IDX_W     = $clog2(MAX_TXNS);
  localparam int CNT_W     = $clog2(MAX_TXNS + 1);
  localparam int NOTE_W    = $clog2(MAX_NOTES + 1);
  localparam int ID_W      = 32;
  localparam int TS_W      = 64;

  // lock modes
  localparam logic [1:0] LK_NONE   = 2'd0;
  localparam logic [1:0] LK_SHARED = 2'd1;
  localparam logic [1:0] LK_EXCL   = 2'd2;

  // concurrency control policies
  localparam logic [1:0] CC_NO_WAIT    = 2'd0;
  localparam logic [1:0] CC_WAIT_DIE   = 2'd1;
  localparam logic [1:0] CC_WOUND_WAIT = 2'd2;
  localparam logic [1:0] CC_DETECT     = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_REPLY = 2'd0;
  localparam logic [1:0] KIND_GRANT = 2'd1;
  localparam logic [1:0] KIND_WOUND = 2'd2;
  localparam logic [1:0] KIND_EDGE  = 2'd3;

  // reply status
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_WAIT      = 2'd1;
  localparam logic [1:0] STAT_ABORT     = 2'd2;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

  // conflict kinds
  localparam logic [1:0] CONF_NONE = 2'd0;
  localparam logic [1:0] CONF_RW   = 2'd1;
  localparam logic [1:0] CONF_WW   = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE, ST_A_CHK, ST_A_PUSH, ST_A_APPEND, ST_A_EDGE_W, ST_A_EDGE_O,
    ST_A_SCAN, ST_A_FIND, ST_A_INSERT, ST_A_WOUND, ST_A_WFIN,
    ST_R_OWN, ST_R_WAIT, ST_R_WD, ST_R_REVIVE, ST_R_PROMO, ST_REPLY
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_CHK, OP_PUSH, OP_APPEND, OP_EDGE_W, OP_EDGE_O,
    OP_SCAN, OP_FIND, OP_INSERT, OP_WOUND, OP_WFIN,
    OP_FIND_OWN, OP_FIND_WAIT, OP_FIND_WD, OP_REVIVE, OP_PROMOTE, OP_REPLY
  } op_t;

  typedef struct packed {
    op_t  op;
    logic start;
  } dp_cmd_t;

  typedef struct packed {
    logic       done;
    logic       hit;
    logic       conf;
    logic [1:0] mode;
    logic       wait_full;
    logic       wd_fits;
    logic       wd_one;
    logic       edge_own;
    logic       flag;
  } dp_stat_t;

  function automatic logic clash(input logic [1:0] a, input logic [1:0] b);
    return (a != LK_NONE) && (b != LK_NONE) && ((a == LK_EXCL) || (b == LK_EXCL));
  endfunction

endpackage

>>> rtl/rlm_dp.sv
`timescale 1ns / 1ps
module rlm_dp import rlm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  dp_cmd_t          cmd,
  output dp_stat_t         stat,
  input  logic             in_command,
  input  logic [ID_W-1:0]  in_txn_id,
  input  logic [TS_W-1:0]  in_txn_stamp,
  input  logic             in_want_exclusive,
  input  logic             cfg_valid,
  input  logic [1:0]       cfg_cc_mode,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [1:0]       out_kind,
  output logic [ID_W-1:0]  out_about_txn,
  output logic [1:0]       out_status,
  output logic [1:0]       out_conflict_kind,
  output logic             out_last
);

  logic [1:0]       cc_mode_r;
  logic [1:0]       lock_r;
  logic [ID_W-1:0]  req_id_r;
  logic [TS_W-1:0]  req_ts_r;
  logic             req_x_r;

  logic [ID_W-1:0]  o_id_r [MAX_TXNS];
  logic [TS_W-1:0]  o_ts_r [MAX_TXNS];
  logic [1:0]       o_ew_r [MAX_TXNS];   // bit1 wounded, bit0 exclusive
  logic [CNT_W-1:0] o_cnt_r;
  logic [ID_W-1:0]  w_id_r [MAX_TXNS];
  logic [TS_W-1:0]  w_ts_r [MAX_TXNS];
  logic             w_x_r  [MAX_TXNS];
  logic [CNT_W-1:0] w_cnt_r;
  logic [ID_W-1:0]  d_id_r [MAX_TXNS];
  logic [CNT_W-1:0] d_cnt_r;

  logic [CNT_W-1:0] idx_r;
  logic             flag_r;
  logic [NOTE_W-1:0] nc_r;
  logic [1:0]       st_r;
  logic [1:0]       ck_r;

  logic             out_valid_r;
  logic [1:0]       out_kind_r;
  logic [ID_W-1:0]  out_about_r;
  logic [1:0]       out_status_r;
  logic [1:0]       out_ck_r;
  logic             out_last_r;

  logic [1:0]       req_lk;
  logic [CNT_W-1:0] idx_m1, wcnt_m1, ocnt_m1;
  logic [IDX_W-1:0] o_ri, w_ri, d_ri, ocnt_i, wcnt_i, dcnt_i;
  logic [ID_W-1:0]  o_rd_id, w_rd_id, d_rd_id;
  logic [TS_W-1:0]  o_rd_ts, w_rd_ts;
  logic [1:0]       o_rd_ew;
  logic             w_rd_x;
  logic             idx_zero, own_full, wait_full;
  logic [1:0]       promo_lk;
  logic             can_promo;
  logic             conf;
  logic [1:0]       head_kind;
  logic             wounded_push;
  logic             work, done, hit, note_req;
  logic [1:0]       note_kind;
  logic [ID_W-1:0]  note_id;
  logic             need, rep, out_free, adv, go, emit;
  logic [CNT_W:0]   wd_sum;

  assign req_lk   = req_x_r ? LK_EXCL : LK_SHARED;
  assign idx_m1   = idx_r - CNT_W'(1);
  assign wcnt_m1  = w_cnt_r - CNT_W'(1);
  assign ocnt_m1  = o_cnt_r - CNT_W'(1);
  assign idx_zero = (idx_r == '0);
  assign own_full  = (o_cnt_r == CNT_W'(MAX_TXNS));
  assign wait_full = (w_cnt_r == CNT_W'(MAX_TXNS));
  assign ocnt_i = o_cnt_r[IDX_W-1:0];
  assign wcnt_i = w_cnt_r[IDX_W-1:0];
  assign dcnt_i = d_cnt_r[IDX_W-1:0];
  assign d_ri   = idx_r[IDX_W-1:0];

  // one read port per list
  always_comb begin
    unique case (cmd.op)
      OP_SCAN, OP_EDGE_O, OP_WOUND, OP_REVIVE, OP_FIND_OWN: o_ri = idx_m1[IDX_W-1:0];
      default:                                              o_ri = ocnt_m1[IDX_W-1:0];
    endcase
    unique case (cmd.op)
      OP_CHK, OP_PROMOTE:
        w_ri = (cc_mode_r == CC_WOUND_WAIT) ? wcnt_m1[IDX_W-1:0] : '0;
      OP_EDGE_W: w_ri = idx_m1[IDX_W-1:0];
      default:   w_ri = idx_r[IDX_W-1:0];
    endcase
  end

  assign o_rd_id = o_id_r[o_ri];
  assign o_rd_ts = o_ts_r[o_ri];
  assign o_rd_ew = o_ew_r[o_ri];
  assign w_rd_id = w_id_r[w_ri];
  assign w_rd_ts = w_ts_r[w_ri];
  assign w_rd_x  = w_x_r[w_ri];
  assign d_rd_id = d_id_r[d_ri];

  assign promo_lk  = w_rd_x ? LK_EXCL : LK_SHARED;
  assign can_promo = (w_cnt_r != '0) && !own_full && !clash(lock_r, promo_lk);
  assign head_kind = (o_cnt_r == '0) ? CONF_NONE :
                     ((o_rd_ew[0] == req_x_r) ? CONF_WW : CONF_RW);
  assign wounded_push = (cc_mode_r == CC_WOUND_WAIT) && (o_cnt_r != '0) && o_rd_ew[1];
  assign wd_sum = {1'b0, d_cnt_r} + {1'b0, o_cnt_r};

  always_comb begin
    conf = clash(lock_r, req_lk);
    if ((cc_mode_r == CC_WOUND_WAIT) && (w_cnt_r != '0) && (req_ts_r > w_rd_ts)) conf = 1'b1;
    if ((cc_mode_r == CC_WAIT_DIE) && (w_cnt_r != '0) && (req_ts_r < w_rd_ts)) conf = 1'b1;
    if ((cc_mode_r == CC_DETECT) && (w_cnt_r != '0)) conf = 1'b1;
  end

  always_comb begin
    work      = 1'b0;
    done      = 1'b0;
    hit       = 1'b0;
    note_req  = 1'b0;
    note_kind = KIND_GRANT;
    note_id   = o_rd_id;
    unique case (cmd.op)
      OP_CHK, OP_PUSH, OP_APPEND, OP_INSERT, OP_WFIN, OP_REPLY: begin
        work = 1'b1;
        done = 1'b1;
      end
      OP_EDGE_W: begin
        work      = !idx_zero;
        done      = idx_zero;
        note_req  = !idx_zero && (req_x_r || w_rd_x);
        note_kind = KIND_EDGE;
        note_id   = w_rd_id;
      end
      OP_EDGE_O: begin
        work      = !idx_zero;
        done      = idx_zero;
        note_req  = !idx_zero;
        note_kind = KIND_EDGE;
      end
      OP_SCAN: begin
        work = !idx_zero;
        done = idx_zero;
      end
      OP_FIND: begin
        done = (idx_r == w_cnt_r) || !(req_ts_r < w_rd_ts);
        work = !done;
      end
      OP_WOUND: begin
        work      = !idx_zero;
        done      = idx_zero;
        note_req  = !idx_zero;
        note_kind = KIND_WOUND;
      end
      OP_REVIVE: begin
        work     = !idx_zero;
        done     = idx_zero;
        note_req = !idx_zero && o_rd_ew[1];
      end
      OP_FIND_OWN: begin
        hit  = !idx_zero && (o_rd_id == req_id_r);
        work = !idx_zero;
        done = idx_zero || hit;
      end
      OP_FIND_WAIT: begin
        hit  = (idx_r != w_cnt_r) && (w_rd_id == req_id_r);
        work = (idx_r != w_cnt_r);
        done = !work || hit;
      end
      OP_FIND_WD: begin
        hit  = (idx_r != d_cnt_r) && (d_rd_id == req_id_r);
        work = (idx_r != d_cnt_r);
        done = !work || hit;
      end
      OP_PROMOTE: begin
        work     = can_promo;
        done     = !can_promo;
        note_req = can_promo;
        note_id  = w_rd_id;
      end
      default: ;
    endcase
  end

  assign out_free = !out_valid_r || out_ready;
  assign need     = note_req && (nc_r < NOTE_W'(MAX_NOTES));
  assign rep      = (cmd.op == OP_REPLY);
  assign adv      = (need || rep) ? out_free : 1'b1;
  assign go       = !cmd.start && work && adv;
  assign emit     = go && (need || rep);

  assign stat.done      = !cmd.start && done && adv;
  assign stat.hit       = hit;
  assign stat.conf      = conf;
  assign stat.mode      = cc_mode_r;
  assign stat.wait_full = wait_full;
  assign stat.wd_fits   = (wd_sum <= (CNT_W+1)'(MAX_TXNS));
  assign stat.wd_one    = (d_cnt_r == CNT_W'(1));
  assign stat.edge_own  = clash(req_lk, lock_r);
  assign stat.flag      = flag_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_mode_r   <= CC_NO_WAIT;
      lock_r      <= LK_NONE;
      o_cnt_r     <= '0;
      w_cnt_r     <= '0;
      d_cnt_r     <= '0;
      idx_r       <= '0;
      flag_r      <= 1'b0;
      nc_r        <= '0;
      st_r        <= STAT_OK;
      ck_r        <= CONF_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) cc_mode_r <= cfg_cc_mode;
      if (emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (go && need) nc_r <= nc_r + NOTE_W'(1);
      if (cmd.op == OP_LOAD) begin
        nc_r <= '0;
        st_r <= in_command ? STAT_NOT_FOUND : STAT_ABORT;
        ck_r <= CONF_NONE;
      end else if (cmd.start) begin
        unique case (cmd.op)
          OP_SCAN: begin
            idx_r  <= o_cnt_r;
            flag_r <= 1'b0;
          end
          OP_EDGE_O, OP_WOUND, OP_REVIVE, OP_FIND_OWN: idx_r <= o_cnt_r;
          OP_EDGE_W: idx_r <= wcnt_m1;
          OP_FIND, OP_FIND_WAIT, OP_FIND_WD: idx_r <= '0;
          default: ;
        endcase
      end else begin
        if (cmd.op == OP_PROMOTE && !can_promo) st_r <= STAT_OK;
        if (go) begin
          unique case (cmd.op)
            OP_PUSH: begin
              if (!own_full) begin
                o_cnt_r <= o_cnt_r + CNT_W'(1);
                lock_r  <= req_lk;
                st_r    <= wounded_push ? STAT_WAIT : STAT_OK;
              end
            end
            OP_APPEND, OP_INSERT: begin
              w_cnt_r <= w_cnt_r + CNT_W'(1);
              st_r    <= STAT_WAIT;
              ck_r    <= head_kind;
            end
            OP_EDGE_W, OP_EDGE_O, OP_REVIVE: idx_r <= idx_m1;
            OP_SCAN: begin
              idx_r <= idx_m1;
              if (cc_mode_r == CC_WAIT_DIE) begin
                if (o_rd_ts < req_ts_r) flag_r <= 1'b1;
              end else if (o_rd_ts > req_ts_r) begin
                flag_r <= 1'b1;
              end
            end
            OP_FIND: idx_r <= idx_r + CNT_W'(1);
            OP_WOUND: begin
              idx_r   <= idx_m1;
              d_cnt_r <= d_cnt_r + CNT_W'(1);
            end
            OP_WFIN: begin
              o_cnt_r <= CNT_W'(1);
              lock_r  <= req_lk;
              st_r    <= STAT_WAIT;
              ck_r    <= (o_ew_r[0][0] == req_x_r) ? CONF_WW : CONF_RW;
            end
            OP_FIND_OWN: begin
              if (hit) begin
                o_cnt_r <= ocnt_m1;
                if (o_cnt_r == CNT_W'(1)) lock_r <= LK_NONE;
              end else begin
                idx_r <= idx_m1;
              end
            end
            OP_FIND_WAIT: begin
              if (hit) w_cnt_r <= wcnt_m1;
              else     idx_r   <= idx_r + CNT_W'(1);
            end
            OP_FIND_WD: begin
              if (hit) d_cnt_r <= d_cnt_r - CNT_W'(1);
              else     idx_r   <= idx_r + CNT_W'(1);
            end
            OP_PROMOTE: begin
              o_cnt_r <= o_cnt_r + CNT_W'(1);
              w_cnt_r <= wcnt_m1;
              lock_r  <= promo_lk;
            end
            default: ;
          endcase
        end
      end
    end
  end

  // lists and payload
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      req_id_r <= in_txn_id;
      req_ts_r <= in_txn_stamp;
      req_x_r  <= in_want_exclusive;
    end
    if (emit) begin
      out_kind_r   <= rep ? KIND_REPLY : note_kind;
      out_about_r  <= rep ? req_id_r : note_id;
      out_status_r <= rep ? st_r : STAT_OK;
      out_ck_r     <= rep ? ck_r : CONF_NONE;
      out_last_r   <= rep;
    end
    if (go) begin
      unique case (cmd.op)
        OP_PUSH: begin
          if (!own_full) begin
            o_id_r[ocnt_i] <= req_id_r;
            o_ts_r[ocnt_i] <= req_ts_r;
            o_ew_r[ocnt_i] <= {wounded_push, req_x_r};
          end
        end
        OP_APPEND: begin
          w_id_r[wcnt_i] <= req_id_r;
          w_ts_r[wcnt_i] <= req_ts_r;
          w_x_r[wcnt_i]  <= req_x_r;
        end
        OP_INSERT: begin
          for (int i = 1; i < MAX_TXNS; i++) begin
            if (IDX_W'(i) > w_ri) begin
              w_id_r[i] <= w_id_r[i-1];
              w_ts_r[i] <= w_ts_r[i-1];
              w_x_r[i]  <= w_x_r[i-1];
            end
          end
          w_id_r[w_ri] <= req_id_r;
          w_ts_r[w_ri] <= req_ts_r;
          w_x_r[w_ri]  <= req_x_r;
        end
        OP_WOUND: d_id_r[dcnt_i] <= o_rd_id;
        OP_REVIVE: if (o_rd_ew[1]) o_ew_r[o_ri] <= {1'b0, o_rd_ew[0]};
        OP_WFIN: begin
          o_id_r[0] <= req_id_r;
          o_ts_r[0] <= req_ts_r;
          o_ew_r[0] <= {1'b1, req_x_r};
        end
        OP_FIND_OWN: begin
          if (hit) begin
            for (int i = 0; i < MAX_TXNS - 1; i++) begin
              if (IDX_W'(i) >= o_ri) begin
                o_id_r[i] <= o_id_r[i+1];
                o_ts_r[i] <= o_ts_r[i+1];
                o_ew_r[i] <= o_ew_r[i+1];
              end
            end
          end
        end
        OP_FIND_WAIT, OP_PROMOTE: begin
          if (cmd.op == OP_PROMOTE || hit) begin
            for (int i = 0; i < MAX_TXNS - 1; i++) begin
              if (IDX_W'(i) >= w_ri) begin
                w_id_r[i] <= w_id_r[i+1];
                w_ts_r[i] <= w_ts_r[i+1];
                w_x_r[i]  <= w_x_r[i+1];
              end
            end
          end
          if (cmd.op == OP_PROMOTE) begin
            o_id_r[ocnt_i] <= w_rd_id;
            o_ts_r[ocnt_i] <= w_rd_ts;
            o_ew_r[ocnt_i] <= {1'b0, w_rd_x};
          end
        end
        OP_FIND_WD: begin
          if (hit) begin
            for (int i = 0; i < MAX_TXNS - 1; i++) begin
              if (IDX_W'(i) >= d_ri) d_id_r[i] <= d_id_r[i+1];
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_about_txn     = out_about_r;
  assign out_status        = out_status_r;
  assign out_conflict_kind = out_ck_r;
  assign out_last          = out_last_r;

endmodule

>>> rtl/rlm_ctrl.sv
`timescale 1ns / 1ps
module rlm_ctrl import rlm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_command,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   entry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      entry_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      entry_r <= (state_nxt != state_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:
        if (in_valid) state_nxt = in_command ? ST_R_OWN : ST_A_CHK;
      ST_A_CHK:
        if (stat.done) begin
          priority if (!stat.conf)                state_nxt = ST_A_PUSH;
          else if (stat.mode == CC_NO_WAIT)       state_nxt = ST_REPLY;
          else if (stat.mode == CC_DETECT)
            state_nxt = stat.wait_full ? ST_REPLY : ST_A_APPEND;
          else                                    state_nxt = ST_A_SCAN;
        end
      ST_A_PUSH:   if (stat.done) state_nxt = ST_REPLY;
      ST_A_APPEND: if (stat.done) state_nxt = ST_A_EDGE_W;
      ST_A_EDGE_W: if (stat.done) state_nxt = stat.edge_own ? ST_A_EDGE_O : ST_REPLY;
      ST_A_EDGE_O: if (stat.done) state_nxt = ST_REPLY;
      ST_A_SCAN:
        if (stat.done) begin
          priority if (stat.flag && stat.mode == CC_WOUND_WAIT)
            state_nxt = stat.wd_fits ? ST_A_WOUND : ST_REPLY;
          else if (stat.flag || stat.wait_full) state_nxt = ST_REPLY;
          else                                  state_nxt = ST_A_FIND;
        end
      ST_A_FIND:   if (stat.done) state_nxt = ST_A_INSERT;
      ST_A_INSERT: if (stat.done) state_nxt = ST_REPLY;
      ST_A_WOUND:  if (stat.done) state_nxt = ST_A_WFIN;
      ST_A_WFIN:   if (stat.done) state_nxt = ST_REPLY;
      ST_R_OWN:    if (stat.done) state_nxt = stat.hit ? ST_R_PROMO : ST_R_WAIT;
      ST_R_WAIT:   if (stat.done) state_nxt = stat.hit ? ST_R_PROMO : ST_R_WD;
      ST_R_WD:
        if (stat.done) begin
          priority if (!stat.hit)  state_nxt = ST_REPLY;
          else if (stat.wd_one)    state_nxt = ST_R_REVIVE;
          else                     state_nxt = ST_R_PROMO;
        end
      ST_R_REVIVE: if (stat.done) state_nxt = ST_R_PROMO;
      ST_R_PROMO:  if (stat.done) state_nxt = ST_REPLY;
      ST_REPLY:    if (stat.done) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    cmd.start = entry_r;
    unique case (state_r)
      ST_IDLE:     cmd.op = in_valid ? OP_LOAD : OP_NONE;
      ST_A_CHK:    cmd.op = OP_CHK;
      ST_A_PUSH:   cmd.op = OP_PUSH;
      ST_A_APPEND: cmd.op = OP_APPEND;
      ST_A_EDGE_W: cmd.op = OP_EDGE_W;
      ST_A_EDGE_O: cmd.op = OP_EDGE_O;
      ST_A_SCAN:   cmd.op = OP_SCAN;
      ST_A_FIND:   cmd.op = OP_FIND;
      ST_A_INSERT: cmd.op = OP_INSERT;
      ST_A_WOUND:  cmd.op = OP_WOUND;
      ST_A_WFIN:   cmd.op = OP_WFIN;
      ST_R_OWN:    cmd.op = OP_FIND_OWN;
      ST_R_WAIT:   cmd.op = OP_FIND_WAIT;
      ST_R_WD:     cmd.op = OP_FIND_WD;
      ST_R_REVIVE: cmd.op = OP_REVIVE;
      ST_R_PROMO:  cmd.op = OP_PROMOTE;
      ST_REPLY:    cmd.op = OP_REPLY;
      default:     cmd.op = OP_NONE;
    endcase
  end

endmodule

>>> rtl/row_lock_manager.sv
`timescale 1ns / 1ps
// Lock manager for one row: shared/exclusive owners, a waiter list kept in
// timestamp order (arrival order under deadlock detection) and a list of
// wounded owners, under a policy picked by cfg_cc_mode (no-wait, wait-die,
// wound-wait, deadlock detection). Each acquire or release beat yields zero
// or more grant, wound or waits-for beats followed by the reply beat
// (out_last set). Items are handled one at a time: a controller steps a
// datapath through phases, each phase opening with a setup step and then
// walking one list entry per cycle, except while an emitted beat finds the
// output register full and out_ready low, through a single read port per
// list. An item runs through 1..5 phases before the reply; a release may
// walk owners, waiters and woundees, the owners again on a revive and the
// waiters on promotion, so up to about five list lengths. in_ready is high
// only between items; the output register lets a finished reply wait while
// the next beat is taken. cfg_ready is always high.
module row_lock_manager import rlm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_command,
  input  logic [ID_W-1:0]  in_txn_id,
  input  logic [TS_W-1:0]  in_txn_stamp,
  input  logic             in_want_exclusive,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_kind,
  output logic [ID_W-1:0]  out_about_txn,
  output logic [1:0]       out_status,
  output logic [1:0]       out_conflict_kind,
  output logic             out_last,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_cc_mode
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // mode register written any time; traffic rules keep writes between items
  assign cfg_ready = 1'b1;

  rlm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_ready   (in_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  rlm_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_command        (in_command),
    .in_txn_id         (in_txn_id),
    .in_txn_stamp      (in_txn_stamp),
    .in_want_exclusive (in_want_exclusive),
    .cfg_valid         (cfg_valid),
    .cfg_cc_mode       (cfg_cc_mode),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_kind          (out_kind),
    .out_about_txn     (out_about_txn),
    .out_status        (out_status),
    .out_conflict_kind (out_conflict_kind),
    .out_last          (out_last)
  );

endmodule

>>> rtl/rlm_chk.sv
`timescale 1ns / 1ps
module rlm_chk import rlm_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [1:0]       out_kind,
  input logic [ID_W-1:0]  out_about_txn,
  input logic [1:0]       out_status,
  input logic             out_last
);

  // a stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_about_txn))
    else $error("result beat changed while stalled");

  a_last_is_reply: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_kind == KIND_REPLY)
    else $error("last beat is not a reply");

  a_note_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_REPLY |-> out_status == STAT_OK && !out_last)
    else $error("notice beat carries reply fields");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("new request taken before previous one finished");

endmodule

bind row_lock_manager rlm_chk u_rlm_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_kind      (out_kind),
  .out_about_txn (out_about_txn),
  .out_status    (out_status),
  .out_last      (out_last)
);

>>> tb/lock_checker.sv
`timescale 1ns / 1ps
// Watches the three channels of the row lock, keeps its own copy of the lock
// and flags every result beat that differs from what that copy predicts.
module lock_checker import rlm_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_ready,
  input  logic            in_command,
  input  logic [ID_W-1:0] in_txn_id,
  input  logic [TS_W-1:0] in_txn_stamp,
  input  logic            in_want_exclusive,
  input  logic            out_valid,
  input  logic            out_ready,
  input  logic [1:0]      out_kind,
  input  logic [ID_W-1:0] out_about_txn,
  input  logic [1:0]      out_status,
  input  logic [1:0]      out_conflict_kind,
  input  logic            out_last,
  input  logic            cfg_valid,
  input  logic            cfg_ready,
  input  logic [1:0]      cfg_cc_mode,
  output int              errors,
  output int              pending
);

  typedef struct {
    logic [1:0]      kind;
    logic [ID_W-1:0] about;
    logic [1:0]      status;
    logic [1:0]      conflict;
    logic            last;
  } lock_beat_t;

  lock_beat_t      beats_due[$];
  logic [1:0]      policy;
  logic [1:0]      held;
  logic [ID_W-1:0] own_id[MAX_TXNS];
  logic [TS_W-1:0] own_ts[MAX_TXNS];
  logic            own_x[MAX_TXNS];
  logic            own_w[MAX_TXNS];
  int              own_n;
  logic [ID_W-1:0] wait_id[MAX_TXNS];
  logic [TS_W-1:0] wait_ts[MAX_TXNS];
  logic            wait_x[MAX_TXNS];
  int              wait_n;
  logic [ID_W-1:0] wd_id[MAX_TXNS];
  int              wd_n;
  logic            wd_x;
  int              notes_n;

  initial begin
    errors = 0;
    pending = 0;
    policy = CC_NO_WAIT;
    held = LK_NONE;
    own_n = 0;
    wait_n = 0;
    wd_n = 0;
    wd_x = 1'b0;
  end

  function automatic bit modes_clash(logic [1:0] a, logic [1:0] b);
    if (a == LK_NONE || b == LK_NONE) return 1'b0;
    return a == LK_EXCL || b == LK_EXCL;
  endfunction

  function automatic logic [1:0] excl_to_mode(logic x);
    return x ? LK_EXCL : LK_SHARED;
  endfunction

  // conflict kind against the newest owner
  function automatic logic [1:0] newest_owner_conflict(logic x);
    if (own_n == 0) return CONF_NONE;
    return (own_x[own_n-1] == x) ? CONF_WW : CONF_RW;
  endfunction

  task automatic add_beat(logic [1:0] k, logic [ID_W-1:0] id, logic [1:0] st,
                          logic [1:0] ck, logic lst);
    lock_beat_t b;
    b.kind = k; b.about = id; b.status = st; b.conflict = ck; b.last = lst;
    beats_due.push_back(b);
  endtask

  // side beats beyond the note limit are dropped, state still moves
  task automatic add_note(logic [1:0] k, logic [ID_W-1:0] id);
    if (notes_n < MAX_NOTES) begin
      add_beat(k, id, STAT_OK, CONF_NONE, 1'b0);
      notes_n++;
    end
  endtask

  task automatic push_owner(logic [ID_W-1:0] id, logic [TS_W-1:0] ts, logic x, logic w);
    own_id[own_n] = id; own_ts[own_n] = ts; own_x[own_n] = x; own_w[own_n] = w;
    own_n++;
  endtask

  // keep waiters in descending stamp order, youngest first
  task automatic insert_waiter(logic [ID_W-1:0] id, logic [TS_W-1:0] ts, logic x);
    int p;
    p = 0;
    while (p < wait_n && ts < wait_ts[p]) p++;
    for (int j = wait_n; j > p; j--) begin
      wait_id[j] = wait_id[j-1]; wait_ts[j] = wait_ts[j-1]; wait_x[j] = wait_x[j-1];
    end
    wait_id[p] = id; wait_ts[p] = ts; wait_x[p] = x;
    wait_n++;
  endtask

  task automatic drop_waiter(int p);
    for (int j = p; j < wait_n - 1; j++) begin
      wait_id[j] = wait_id[j+1]; wait_ts[j] = wait_ts[j+1]; wait_x[j] = wait_x[j+1];
    end
    wait_n--;
  endtask

  task automatic predict_acquire(logic [ID_W-1:0] id, logic [TS_W-1:0] ts, logic x);
    logic [1:0] req, st, ck;
    bit conf, ok_to_wait, wound, ready;
    req = excl_to_mode(x);
    st = STAT_ABORT;
    ck = CONF_NONE;
    conf = modes_clash(held, req);
    if (policy == CC_WOUND_WAIT && !conf && wait_n > 0 && ts > wait_ts[wait_n-1]) conf = 1;
    if (policy == CC_WAIT_DIE && !conf && wait_n > 0 && ts < wait_ts[0]) conf = 1;
    if (policy == CC_DETECT && wait_n > 0) conf = 1;
    if (conf) begin
      case (policy)
        CC_DETECT: begin
          if (wait_n < MAX_TXNS) begin
            wait_id[wait_n] = id; wait_ts[wait_n] = ts; wait_x[wait_n] = x;
            wait_n++;
            st = STAT_WAIT;
            ck = newest_owner_conflict(x);
            for (int i = wait_n - 1; i > 0; i--)
              if (modes_clash(req, excl_to_mode(wait_x[i-1]))) add_note(KIND_EDGE, wait_id[i-1]);
            if (modes_clash(req, held))
              for (int i = own_n; i > 0; i--) add_note(KIND_EDGE, own_id[i-1]);
          end
        end
        CC_WAIT_DIE: begin
          ok_to_wait = 1;
          for (int i = 0; i < own_n; i++)
            if (own_ts[i] < ts) ok_to_wait = 0;
          if (ok_to_wait && wait_n < MAX_TXNS) begin
            insert_waiter(id, ts, x);
            st = STAT_WAIT;
            ck = newest_owner_conflict(x);
          end
        end
        CC_WOUND_WAIT: begin
          wound = 0;
          for (int i = 0; i < own_n; i++)
            if (own_ts[i] > ts) wound = 1;
          if (wound) begin
            if (wd_n + own_n <= MAX_TXNS) begin
              for (int i = own_n; i > 0; i--) begin
                add_note(KIND_WOUND, own_id[i-1]);
                wd_id[wd_n] = own_id[i-1];
                wd_n++;
              end
              wd_x = own_x[0];
              own_n = 0;
              push_owner(id, ts, x, 1'b1);
              held = req;
              st = STAT_WAIT;
              ck = (wd_x == x) ? CONF_WW : CONF_RW;
            end
          end else if (wait_n < MAX_TXNS) begin
            insert_waiter(id, ts, x);
            st = STAT_WAIT;
            ck = newest_owner_conflict(x);
          end
        end
        default: ;  // no-wait: abort
      endcase
    end else if (own_n < MAX_TXNS) begin
      ready = own_n == 0 || !own_w[own_n-1];
      push_owner(id, ts, x, 1'b0);
      held = req;
      if (policy == CC_WOUND_WAIT && !ready) begin
        own_w[own_n-1] = 1'b1;
        st = STAT_WAIT;
      end else begin
        st = STAT_OK;
      end
    end
    add_beat(KIND_REPLY, id, st, ck, 1'b1);
  endtask

  task automatic predict_release(logic [ID_W-1:0] id);
    bit found;
    int p;
    logic [1:0] t;
    found = 0;
    for (int i = own_n; i > 0 && !found; i--) begin
      if (own_id[i-1] == id) begin
        for (int j = i - 1; j < own_n - 1; j++) begin
          own_id[j] = own_id[j+1]; own_ts[j] = own_ts[j+1];
          own_x[j] = own_x[j+1]; own_w[j] = own_w[j+1];
        end
        own_n--;
        if (own_n == 0) held = LK_NONE;
        found = 1;
      end
    end
    for (int i = 0; i < wait_n && !found; i++) begin
      if (wait_id[i] == id) begin
        drop_waiter(i);
        found = 1;
      end
    end
    for (int i = 0; i < wd_n && !found; i++) begin
      if (wd_id[i] == id) begin
        for (int j = i; j < wd_n - 1; j++) wd_id[j] = wd_id[j+1];
        wd_n--;
        found = 1;
        // last woundee gone: wounded owners come back to life
        if (wd_n == 0)
          for (int k = own_n; k > 0; k--)
            if (own_w[k-1]) begin
              own_w[k-1] = 1'b0;
              add_note(KIND_GRANT, own_id[k-1]);
            end
      end
    end
    if (!found) begin
      add_beat(KIND_REPLY, id, STAT_NOT_FOUND, CONF_NONE, 1'b1);
      return;
    end
    while (wait_n > 0 && own_n < MAX_TXNS) begin
      p = (policy == CC_WOUND_WAIT) ? wait_n - 1 : 0;
      t = excl_to_mode(wait_x[p]);
      if (modes_clash(held, t)) break;
      push_owner(wait_id[p], wait_ts[p], wait_x[p], 1'b0);
      add_note(KIND_GRANT, wait_id[p]);
      drop_waiter(p);
      held = t;
    end
    add_beat(KIND_REPLY, id, STAT_OK, CONF_NONE, 1'b1);
  endtask

  always @(posedge clk) begin
    lock_beat_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) policy = cfg_cc_mode;
      if (in_valid && in_ready) begin
        notes_n = 0;
        if (in_command) predict_release(in_txn_id);
        else predict_acquire(in_txn_id, in_txn_stamp, in_want_exclusive);
      end
      if (out_valid && out_ready) begin
        if (beats_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected beat: kind %0d txn %h status %0d", out_kind,
                     out_about_txn, out_status);
        end else begin
          want = beats_due.pop_front();
          if (out_kind !== want.kind || out_about_txn !== want.about ||
              out_status !== want.status || out_conflict_kind !== want.conflict ||
              out_last !== want.last) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch: exp kind %0d txn %h st %0d ck %0d last %0d,",
                        " got %0d %h %0d %0d %0d"},
                       want.kind, want.about, want.status, want.conflict, want.last,
                       out_kind, out_about_txn, out_status, out_conflict_kind, out_last);
          end
        end
      end
      pending = beats_due.size();
    end
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the row lock. The checker beside the block does
// all prediction; this module only drives beats and decides pass/fail.
module testbench;
  import rlm_pkg::*;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic            in_command = 1'b0;
  logic [ID_W-1:0] in_txn_id = '0;
  logic [TS_W-1:0] in_txn_stamp = '0;
  logic            in_want_exclusive = 1'b0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [1:0]      out_kind;
  logic [ID_W-1:0] out_about_txn;
  logic [1:0]      out_status;
  logic [1:0]      out_conflict_kind;
  logic            out_last;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [1:0]      cfg_cc_mode = CC_NO_WAIT;
  int              errors;
  int              pending;

  localparam bit CMD_ACQUIRE = 1'b0;
  localparam bit CMD_RELEASE = 1'b1;
  localparam int POOL_N      = 24;

  logic [ID_W-1:0] id_pool[POOL_N];
  int              burst_left = 0;
  logic [15:0]     stall_lfsr = 16'hACE1;
  int unsigned     cyc = 0;

  always #5 clk = ~clk;

  row_lock_manager dut (.*);
  lock_checker chk (.*);

  // Receiver: long stretches of always-ready alternate with a pseudo-random
  // stall pattern that can land on any beat of a multi-beat answer.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    stall_lfsr <= {stall_lfsr[14:0], stall_lfsr[15] ^ stall_lfsr[13] ^
                   stall_lfsr[12] ^ stall_lfsr[10]};
    out_ready <= cyc[9] ? 1'b1 : (stall_lfsr[1:0] != 2'b00);
  end

  // Wait until every predicted beat is back, then let the block settle.
  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_policy(logic [1:0] m);
    in_valid <= 1'b0;
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_cc_mode <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    burst_left = 0;
  endtask

  // One input beat; valid stays high across a burst, drops only in gaps.
  task automatic send_beat(bit cmd, logic [ID_W-1:0] id, logic [TS_W-1:0] ts, bit x);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_command <= cmd;
    in_txn_id <= id;
    in_txn_stamp <= ts;
    in_want_exclusive <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [TS_W-1:0] pick_stamp();
    case ($urandom_range(0, 9))
      0: return {$urandom, $urandom};
      1: return '0;
      2: return '1;
      default: return TS_W'($urandom_range(0, 63));
    endcase
  endfunction

  task automatic random_beat();
    logic [ID_W-1:0] id;
    id = id_pool[$urandom_range(0, POOL_N - 1)];
    if ($urandom_range(0, 99) < 58)
      send_beat(CMD_ACQUIRE, id, pick_stamp(), $urandom_range(0, 99) < 30);
    else if ($urandom_range(0, 19) == 0)
      send_beat(CMD_RELEASE, $urandom, pick_stamp(), $urandom_range(0, 1));  // likely unknown
    else
      send_beat(CMD_RELEASE, id, pick_stamp(), $urandom_range(0, 1));
  endtask

  initial begin
    logic [1:0] plan[8];
    plan = '{CC_NO_WAIT, CC_DETECT, CC_WAIT_DIE, CC_WOUND_WAIT,
             CC_WOUND_WAIT, CC_DETECT, CC_WAIT_DIE, CC_NO_WAIT};
    for (int i = 0; i < POOL_N; i++) id_pool[i] = $urandom;
    id_pool[0] = '0;
    id_pool[1] = '1;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no-wait: shared sharing, exclusive abort, unknown release
    send_beat(CMD_ACQUIRE, '0, '0, 1'b0);
    send_beat(CMD_ACQUIRE, '1, '1, 1'b0);
    send_beat(CMD_ACQUIRE, 32'h5, 64'd3, 1'b1);
    send_beat(CMD_RELEASE, '0, '0, 1'b0);
    send_beat(CMD_RELEASE, '1, '0, 1'b0);
    send_beat(CMD_RELEASE, '0, '0, 1'b0);

    // wound-wait: wound, woundee release, revive grant
    set_policy(CC_WOUND_WAIT);
    send_beat(CMD_ACQUIRE, 32'h1, 64'd50, 1'b0);
    send_beat(CMD_ACQUIRE, 32'h2, 64'd10, 1'b1);
    send_beat(CMD_ACQUIRE, 32'h3, 64'd5, 1'b0);
    send_beat(CMD_ACQUIRE, 32'h4, 64'd70, 1'b1);
    send_beat(CMD_RELEASE, 32'h1, '0, 1'b0);
    send_beat(CMD_RELEASE, 32'h2, '0, 1'b0);
    send_beat(CMD_RELEASE, 32'h3, '0, 1'b0);

    // wait-die: older waits, younger dies
    set_policy(CC_WAIT_DIE);
    send_beat(CMD_ACQUIRE, 32'h7, 64'd20, 1'b1);
    send_beat(CMD_ACQUIRE, 32'h8, 64'd9, 1'b0);
    send_beat(CMD_ACQUIRE, 32'h9, 64'd40, 1'b1);
    send_beat(CMD_RELEASE, 32'h7, '0, 1'b0);

    // detection: edges to waiters and owners
    set_policy(CC_DETECT);
    send_beat(CMD_ACQUIRE, 32'hA, 64'd1, 1'b1);
    send_beat(CMD_ACQUIRE, 32'hB, 64'd2, 1'b0);
    send_beat(CMD_RELEASE, 32'h8, '0, 1'b0);
    send_beat(CMD_RELEASE, 32'hA, '0, 1'b0);

    // random phases over every policy, extremes first and last
    for (int ph = 0; ph < 8; ph++) begin
      set_policy(plan[ph]);
      for (int n = 0; n < 48; n++) begin
        if (ph == 4 && n == 24) begin
          in_valid <= 1'b0;
          wait_drained();
        end
        random_beat();
      end
    end
    in_valid <= 1'b0;

    wait_drained();
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

endmodule
